FILE: sv/ryc420_pkg.sv
`default_nettype none

package ryc420_pkg;

    // Field and datapath widths.
    localparam int PIX_W    = 8;
    localparam int CFG_W    = 12;
    localparam int CHROMA_W = 2 * PIX_W;
    localparam int FRAC_W   = 12;
    localparam int F_W      = 20;
    localparam int SUM_W    = F_W + 1;
    localparam int P_W      = 24;

    // Line store sizing for the default maximum row length.
    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int LINE_DEPTH_DEF   = (MAX_WIDTH_DEF + 1) / 2;
    localparam int LINE_ADDR_W_DEF  = (LINE_DEPTH_DEF > 1) ? $clog2(LINE_DEPTH_DEF) : 1;

    localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH = 12'd640;

    // Offsets of the studio-range encoding.
    localparam logic [PIX_W-1:0]        LUMA_OFS   = 8'd16;
    localparam logic signed [PIX_W+1:0] CHROMA_MID = 10'sd128;
    localparam logic [SUM_W-1:0]        CHROMA_OFS = 21'd524288;

    // Forward conversion coefficients, Q0.12 unsigned.
    localparam logic [11:0] K_Y_R  = 12'd1053;
    localparam logic [11:0] K_Y_G  = 12'd2064;
    localparam logic [11:0] K_Y_B  = 12'd401;
    localparam logic [11:0] K_CB_R = 12'd606;
    localparam logic [11:0] K_CB_G = 12'd1192;
    localparam logic [11:0] K_CB_B = 12'd1798;
    localparam logic [11:0] K_CR_R = 12'd1798;
    localparam logic [11:0] K_CR_G = 12'd1507;
    localparam logic [11:0] K_CR_B = 12'd291;

    // Inverse conversion coefficients, Q12 signed.
    localparam logic signed [15:0] K_Y   = 16'sd4768;
    localparam logic signed [15:0] K_R_V = 16'sd6537;
    localparam logic signed [15:0] K_G_U = 16'sd1606;
    localparam logic signed [15:0] K_G_V = 16'sd3330;
    localparam logic signed [15:0] K_B_U = 16'sd8262;

    // Drops the fraction of a Q12 sum and clamps it to 0..255.
    function automatic logic [PIX_W-1:0] sat_q12(input logic signed [P_W-1:0] acc);
        logic [P_W-FRAC_W-1:0] v;
        v = acc[P_W-1:FRAC_W];
        if (acc[P_W-1]) begin
            return '0;
        end else if (|v[P_W-FRAC_W-1:PIX_W]) begin
            return '1;
        end else begin
            return v[PIX_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/ryc420_line_store.sv
`default_nettype none

module ryc420_line_store
    import ryc420_pkg::*;
#(
    parameter int DEPTH  = LINE_DEPTH_DEF,
    parameter int ADDR_W = LINE_ADDR_W_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rd_en,
    input  wire logic [ADDR_W-1:0]   i_rd_addr,
    output logic      [CHROMA_W-1:0] o_rd_data,
    input  wire logic                i_wr_en,
    input  wire logic [ADDR_W-1:0]   i_wr_addr,
    input  wire logic [CHROMA_W-1:0] i_wr_data
);

    logic [CHROMA_W-1:0] r_mem [DEPTH];
    logic [CHROMA_W-1:0] r_q;
    logic [CHROMA_W-1:0] r_fwd_data;
    logic                r_fwd_hit;

    // One write and one registered read per cycle. A write landing on the
    // entry being read in the same cycle is forwarded to the read data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_q;

endmodule

`default_nettype wire

FILE: sv/rgb_ycbcr_420_roundtrip_unit.sv
// RGB to BT.601 YCbCr 4:2:0 and back, one raster-order pixel per transaction.
// Input stream (s side): tdata carries red, green, blue; tuser is frame start,
// which forces the pixel to row 0, column 0. Output stream (m side): tdata
// carries luma, Cb, Cr and the reconstructed, saturated red, green and blue.
// Every pixel uses the chroma of the top-left pixel of its 2x2 block; that
// chroma is kept in a register for the odd column and in a line store, one
// entry per column pair, for the odd row below.
// The row length is written through i_cfg_we / i_cfg_wdata while the stream
// is idle; 0 acts as 1 and values above MAX_WIDTH act as MAX_WIDTH.
// Throughput is one pixel per clock while the receiver keeps up. A pixel
// passes through five register stages: input, forward products with the
// line store read, chroma select, inverse products, saturation and output.
// Reset clears the pipeline, the row and column position, the held chroma and
// sets the row length to 640. The line store is not cleared; an odd row only
// reads entries that the even row above has written.
// When the receiver stalls, the result holds in the output register and
// earlier stages keep filling; input ready drops only once every stage holds
// a pixel and the output is not being taken.
`default_nettype none

module rgb_ycbcr_420_roundtrip_unit
    import ryc420_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [23:0]        i_s_tdata,   // red, green, blue
    input  wire logic               i_s_tuser,   // frame_start
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic      [47:0]        o_m_tdata,   // luma, blue_diff, red_diff,
                                                 // red_out, green_out, blue_out
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata  // image_width
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CMP_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    // Configuration and position state.
    logic [CFG_W-1:0] r_image_width;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_odd, n_odd;
    logic [COL_W-1:0] w_col_cur;
    logic             w_odd_cur;
    logic [CMP_W-1:0] w_width_ext, w_eff, w_col_inc;

    // Stage valids and the ready chain.
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy_o;
    logic w_accept;

    // Stage 1: captured pixel and its position.
    logic [PIX_W-1:0]  r_s1_red, r_s1_green, r_s1_blue;
    logic              r_s1_odd, r_s1_col_odd;
    logic [SLOT_W-1:0] r_s1_slot;

    // Stage 2: forward products.
    logic [F_W-1:0]    r_s2_p_yr, r_s2_p_yg, r_s2_p_yb;
    logic [F_W-1:0]    r_s2_p_cbr, r_s2_p_cbg, r_s2_p_cbb;
    logic [F_W-1:0]    r_s2_p_crr, r_s2_p_crg, r_s2_p_crb;
    logic              r_s2_odd, r_s2_col_odd;
    logic [SLOT_W-1:0] r_s2_slot;
    logic [SUM_W-1:0]  w_y_sum, w_cb_sum, w_cr_sum;
    logic [PIX_W-1:0]  w_y;
    logic [CHROMA_W-1:0] w_chroma_new, w_chroma, w_line_chroma;
    logic              w_chroma_we;
    logic [CHROMA_W-1:0] r_held;

    // Stage 3: luma and the shared chroma.
    logic [PIX_W-1:0]  r_s3_y, r_s3_cb, r_s3_cr;
    logic signed [PIX_W+1:0] w_yc_s, w_bc_s, w_rc_s;

    // Stage 4: inverse products.
    logic signed [P_W-1:0] r_s4_p_y, r_s4_p_rv, r_s4_p_gu, r_s4_p_gv, r_s4_p_bu;
    logic [PIX_W-1:0]  r_s4_y, r_s4_cb, r_s4_cr;
    logic signed [P_W-1:0] w_acc_r, w_acc_g, w_acc_b;

    // Output register.
    logic [47:0] r_o_data;

    // A stage takes new contents when it is empty or its contents move on.
    assign w_rdy_o    = !r_vo || i_m_tready;
    assign w_rdy4     = !r_v4 || w_rdy_o;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_s_tready = w_rdy1;
    assign w_accept   = i_s_tvalid && w_rdy1;

    // Row and column advance for the accepted pixel.
    always_comb begin
        w_col_cur   = i_s_tuser ? '0 : r_col;
        w_odd_cur   = i_s_tuser ? 1'b0 : r_odd;
        w_width_ext = CMP_W'(r_image_width);
        if (w_width_ext == '0) begin
            w_eff = CMP_W'(1);
        end else if (w_width_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_width_ext;
        end
        w_col_inc = CMP_W'(w_col_cur) + CMP_W'(1);
        n_col     = r_col;
        n_odd     = r_odd;
        if (w_accept) begin
            if (w_col_inc >= w_eff) begin
                n_col = '0;
                n_odd = !w_odd_cur;
            end else begin
                n_col = w_col_inc[COL_W-1:0];
                n_odd = w_odd_cur;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= RESET_IMAGE_WIDTH;
            r_col         <= '0;
            r_odd         <= 1'b0;
            r_held        <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_v4          <= 1'b0;
            r_vo          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_image_width <= i_cfg_wdata;
            end
            r_col <= n_col;
            r_odd <= n_odd;
            if (w_chroma_we) begin
                r_held <= w_chroma_new;
            end
            if (w_rdy1) begin
                r_v1 <= i_s_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_rdy_o) begin
                r_vo <= r_v4;
            end
        end
    end

    // Stage 1 capture.
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_red     <= i_s_tdata[7:0];
            r_s1_green   <= i_s_tdata[15:8];
            r_s1_blue    <= i_s_tdata[23:16];
            r_s1_odd     <= w_odd_cur;
            r_s1_col_odd <= w_col_cur[0];
            r_s1_slot    <= SLOT_W'(w_col_cur >> 1);
        end
    end

    // Stage 2: constant multiplications for Y, Cb and Cr.
    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_p_yr    <= F_W'(r_s1_red)   * F_W'(K_Y_R);
            r_s2_p_yg    <= F_W'(r_s1_green) * F_W'(K_Y_G);
            r_s2_p_yb    <= F_W'(r_s1_blue)  * F_W'(K_Y_B);
            r_s2_p_cbr   <= F_W'(r_s1_red)   * F_W'(K_CB_R);
            r_s2_p_cbg   <= F_W'(r_s1_green) * F_W'(K_CB_G);
            r_s2_p_cbb   <= F_W'(r_s1_blue)  * F_W'(K_CB_B);
            r_s2_p_crr   <= F_W'(r_s1_red)   * F_W'(K_CR_R);
            r_s2_p_crg   <= F_W'(r_s1_green) * F_W'(K_CR_G);
            r_s2_p_crb   <= F_W'(r_s1_blue)  * F_W'(K_CR_B);
            r_s2_odd     <= r_s1_odd;
            r_s2_col_odd <= r_s1_col_odd;
            r_s2_slot    <= r_s1_slot;
        end
    end

    // Chroma line store, read as the pixel enters stage 2.
    ryc420_line_store #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rdy2),
        .i_rd_addr (r_s1_slot),
        .o_rd_data (w_line_chroma),
        .i_wr_en   (w_chroma_we),
        .i_wr_addr (r_s2_slot),
        .i_wr_data (w_chroma_new)
    );

    // Sums, and the choice of the block chroma. The top-left pixel of a
    // block computes it; its right neighbor takes the held copy and the row
    // below takes the line store entry.
    always_comb begin
        w_y_sum  = SUM_W'(r_s2_p_yr) + SUM_W'(r_s2_p_yg) + SUM_W'(r_s2_p_yb);
        w_cb_sum = CHROMA_OFS + SUM_W'(r_s2_p_cbb) - SUM_W'(r_s2_p_cbr) - SUM_W'(r_s2_p_cbg);
        w_cr_sum = CHROMA_OFS + SUM_W'(r_s2_p_crr) - SUM_W'(r_s2_p_crg) - SUM_W'(r_s2_p_crb);
        w_y      = w_y_sum[FRAC_W +: PIX_W] + LUMA_OFS;
        w_chroma_new = {w_cb_sum[FRAC_W +: PIX_W], w_cr_sum[FRAC_W +: PIX_W]};
        if (r_s2_odd) begin
            w_chroma = w_line_chroma;
        end else if (!r_s2_col_odd) begin
            w_chroma = w_chroma_new;
        end else begin
            w_chroma = r_held;
        end
    end

    assign w_chroma_we = w_rdy3 && r_v2 && !r_s2_odd && !r_s2_col_odd;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_y  <= w_y;
            r_s3_cb <= w_chroma[CHROMA_W-1:PIX_W];
            r_s3_cr <= w_chroma[PIX_W-1:0];
        end
    end

    // Stage 4: centered components and inverse products.
    always_comb begin
        w_yc_s = signed'({2'b00, r_s3_y - LUMA_OFS});
        w_bc_s = signed'({2'b00, r_s3_cb}) - CHROMA_MID;
        w_rc_s = signed'({2'b00, r_s3_cr}) - CHROMA_MID;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_s4_p_y  <= P_W'(w_yc_s) * P_W'(K_Y);
            r_s4_p_rv <= P_W'(w_rc_s) * P_W'(K_R_V);
            r_s4_p_gu <= P_W'(w_bc_s) * P_W'(K_G_U);
            r_s4_p_gv <= P_W'(w_rc_s) * P_W'(K_G_V);
            r_s4_p_bu <= P_W'(w_bc_s) * P_W'(K_B_U);
            r_s4_y    <= r_s3_y;
            r_s4_cb   <= r_s3_cb;
            r_s4_cr   <= r_s3_cr;
        end
    end

    // Final sums, saturation and the output register.
    always_comb begin
        w_acc_r = r_s4_p_y + r_s4_p_rv;
        w_acc_g = r_s4_p_y - r_s4_p_gu - r_s4_p_gv;
        w_acc_b = r_s4_p_y + r_s4_p_bu;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_o) begin
            r_o_data <= {sat_q12(w_acc_b), sat_q12(w_acc_g), sat_q12(w_acc_r),
                         r_s4_cr, r_s4_cb, r_s4_y};
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = r_o_data;

    // An empty output register always lets a new pixel in.
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input not ready although the output register is empty");

    // An accepted pixel always lands in stage 1.
    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v1)
        else $error("accepted pixel lost at stage 1");

    // The column never reaches the maximum row length.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_col) < CMP_W'(MAX_WIDTH))
        else $error("column position beyond maximum row length");

    // The held chroma changes only when a top-left pixel leaves stage 2.
    a_held_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_held) |-> $past(w_chroma_we))
        else $error("held chroma changed without a block start");

endmodule

`default_nettype wire
